// File: src/nvbb_pkg.sv
// Package with widths, codes and types shared by the voxel bounding box block.
`default_nettype none

package nvbb_pkg;

    localparam int MAX_DIM   = 1024;
    localparam int FRAC_BITS = 12;

    localparam int NUM_AXES  = 3;
    localparam int COORD_W   = $clog2(MAX_DIM);
    localparam int SIZE_W    = COORD_W + 1;
    localparam int VALUE_W   = 16;
    localparam int MARGIN_W  = 16;
    localparam int AXIS_W    = 2;
    localparam int PAD_W     = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = MARGIN_W;

    typedef logic [COORD_W-1:0] coord_t;

    typedef enum logic [AXIS_W-1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MARGIN = 2'd0,
        CFG_SIZE_X = 2'd1,
        CFG_SIZE_Y = 2'd2,
        CFG_SIZE_Z = 2'd3
    } cfg_idx_e;

    typedef struct packed {
        logic [MARGIN_W-1:0]               margin_fraction;
        logic [NUM_AXES-1:0][SIZE_W-1:0]   size;
    } cfg_t;

    typedef struct packed {
        logic                        found;
        coord_t [NUM_AXES-1:0]       lo;
        coord_t [NUM_AXES-1:0]       hi;
    } box_t;

    localparam box_t BOX_CLEAR = '{found: 1'b0, lo: '1, hi: '0};

endpackage

`default_nettype wire

// File: src/nvbb_if.sv
// Channel interfaces for voxel input words and axis result words.
`default_nettype none

interface nvbb_voxel_if;
    logic                          valid;
    logic                          ready;
    logic [nvbb_pkg::VALUE_W-1:0]  voxel_value;
    nvbb_pkg::coord_t              pos_x;
    nvbb_pkg::coord_t              pos_y;
    nvbb_pkg::coord_t              pos_z;
    logic                          end_of_set;

    modport source (
        output valid, voxel_value, pos_x, pos_y, pos_z, end_of_set,
        input  ready
    );
    modport sink (
        input  valid, voxel_value, pos_x, pos_y, pos_z, end_of_set,
        output ready
    );
endinterface

interface nvbb_result_if;
    logic                               valid;
    logic                               ready;
    logic [nvbb_pkg::AXIS_W-1:0]        axis;
    logic                               found;
    logic signed [nvbb_pkg::PAD_W-1:0]  padded_min;
    logic [nvbb_pkg::PAD_W-1:0]         padded_max;
    nvbb_pkg::coord_t                   clipped_min;
    nvbb_pkg::coord_t                   clipped_max;
    logic                               final_axis;

    modport source (
        output valid, axis, found, padded_min, padded_max, clipped_min, clipped_max,
               final_axis,
        input  ready
    );
    modport sink (
        input  valid, axis, found, padded_min, padded_max, clipped_min, clipped_max,
               final_axis,
        output ready
    );
endinterface

`default_nettype wire

// File: src/nvbb_cfg.sv
// Configuration registers: margin fraction and the three volume sizes.
`default_nettype none

module nvbb_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [nvbb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [nvbb_pkg::CFG_DATA_W-1:0]   cfg_data,
    output nvbb_pkg::cfg_t                         cfg
);

    localparam logic [nvbb_pkg::SIZE_W-1:0] SIZE_RESET = nvbb_pkg::SIZE_W'(256);

    nvbb_pkg::cfg_t cfg_reg;
    nvbb_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (nvbb_pkg::cfg_idx_e'(cfg_index))
                nvbb_pkg::CFG_MARGIN: cfg_next.margin_fraction = cfg_data;
                nvbb_pkg::CFG_SIZE_X:
                    cfg_next.size[0] = cfg_data[nvbb_pkg::SIZE_W-1:0];
                nvbb_pkg::CFG_SIZE_Y:
                    cfg_next.size[1] = cfg_data[nvbb_pkg::SIZE_W-1:0];
                nvbb_pkg::CFG_SIZE_Z:
                    cfg_next.size[2] = cfg_data[nvbb_pkg::SIZE_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.margin_fraction <= '0;
            cfg_reg.size            <= {nvbb_pkg::NUM_AXES{SIZE_RESET}};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: src/nvbb_accum.sv
// Running minimum and maximum of nonzero voxel coordinates, handed off at set end.
`default_nettype none

module nvbb_accum (
    input  wire logic          clk,
    input  wire logic          rst_n,
    nvbb_voxel_if.sink         vox,
    input  wire logic          snap_free,
    output logic               snap_load,
    output nvbb_pkg::box_t     snap_box
);

    nvbb_pkg::box_t box_reg;
    nvbb_pkg::box_t box_next;
    nvbb_pkg::box_t merged;
    nvbb_pkg::coord_t [nvbb_pkg::NUM_AXES-1:0] pos;
    logic accept;

    assign vox.ready = snap_free;
    assign accept    = vox.valid && vox.ready;
    assign pos       = {vox.pos_z, vox.pos_y, vox.pos_x};

    // The voxel flagged last still counts toward the box it closes.
    always_comb
    begin
        merged = box_reg;
        if (vox.voxel_value != '0)
        begin
            merged.found = 1'b1;
            for (int a = 0; a < nvbb_pkg::NUM_AXES; a++)
            begin
                if (pos[a] < box_reg.lo[a])
                begin
                    merged.lo[a] = pos[a];
                end
                if (pos[a] > box_reg.hi[a])
                begin
                    merged.hi[a] = pos[a];
                end
            end
        end
    end

    always_comb
    begin
        box_next = box_reg;
        if (accept)
        begin
            box_next = vox.end_of_set ? nvbb_pkg::BOX_CLEAR : merged;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg <= nvbb_pkg::BOX_CLEAR;
        end
        else
        begin
            box_reg <= box_next;
        end
    end

    assign snap_load = accept && vox.end_of_set;
    assign snap_box  = merged;

endmodule

`default_nettype wire

// File: src/nvbb_emit.sv
// Per-axis result pipeline: margin multiply, then padding, clipping and output register.
`default_nettype none

module nvbb_emit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire nvbb_pkg::cfg_t    cfg,
    input  wire logic              snap_load,
    input  wire nvbb_pkg::box_t    snap_box,
    output logic                   snap_free,
    nvbb_result_if.source          res
);

    localparam int PROD_W  = nvbb_pkg::MARGIN_W + nvbb_pkg::COORD_W;
    localparam int MGN_W   = PROD_W - nvbb_pkg::FRAC_BITS;
    localparam int WIDE_W  = nvbb_pkg::PAD_W + 2;
    localparam logic signed [WIDE_W-1:0] PMIN_FLOOR = WIDE_W'(-(2 ** (nvbb_pkg::PAD_W - 1)));
    localparam logic signed [WIDE_W-1:0] PMAX_CEIL  = WIDE_W'(2 ** nvbb_pkg::PAD_W - 1);
    localparam logic [nvbb_pkg::SIZE_W-1:0] SIZE_MAX = nvbb_pkg::SIZE_W'(nvbb_pkg::MAX_DIM);

    // Snapshot of a closed box and the axis to issue next.
    logic              snap_valid_reg;
    nvbb_pkg::box_t    snap_box_reg;
    nvbb_pkg::axis_e   issue_axis_reg;
    nvbb_pkg::axis_e   issue_axis_next;

    // Margin stage.
    logic              m_valid_reg;
    nvbb_pkg::axis_e   m_axis_reg;
    logic              m_found_reg;
    nvbb_pkg::coord_t  m_lo_reg;
    nvbb_pkg::coord_t  m_hi_reg;
    logic [MGN_W-1:0]  m_margin_reg;
    nvbb_pkg::coord_t  m_lim_reg;

    // Output register.
    logic              out_valid_reg;

    logic              out_load;
    logic              m_ready;
    logic              issue;
    logic              last_issue;

    nvbb_pkg::coord_t           sel_lo;
    nvbb_pkg::coord_t           sel_hi;
    logic [nvbb_pkg::SIZE_W-1:0] sel_size;
    nvbb_pkg::coord_t           ext;
    logic [PROD_W-1:0]          product;
    nvbb_pkg::coord_t           lim;

    logic signed [WIDE_W-1:0]   pmin_w;
    logic signed [WIDE_W-1:0]   pmax_w;
    logic signed [WIDE_W-1:0]   lim_w;
    nvbb_pkg::coord_t           cmin;
    nvbb_pkg::coord_t           cmax;

    assign out_load   = !out_valid_reg || res.ready;
    assign m_ready    = !m_valid_reg || out_load;
    assign issue      = snap_valid_reg && m_ready;
    assign last_issue = issue && (issue_axis_reg == nvbb_pkg::AXIS_Z);
    assign snap_free  = !snap_valid_reg || last_issue;

    always_comb
    begin
        unique case (issue_axis_reg)
            nvbb_pkg::AXIS_X: issue_axis_next = nvbb_pkg::AXIS_Y;
            nvbb_pkg::AXIS_Y: issue_axis_next = nvbb_pkg::AXIS_Z;
            default:          issue_axis_next = nvbb_pkg::AXIS_X;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
            issue_axis_reg <= nvbb_pkg::AXIS_X;
        end
        else if (snap_load)
        begin
            snap_valid_reg <= 1'b1;
            issue_axis_reg <= nvbb_pkg::AXIS_X;
        end
        else if (issue)
        begin
            snap_valid_reg <= !last_issue;
            issue_axis_reg <= issue_axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_load)
        begin
            snap_box_reg <= snap_box;
        end
    end

    always_comb
    begin
        unique case (issue_axis_reg)
            nvbb_pkg::AXIS_X:
            begin
                sel_lo   = snap_box_reg.lo[0];
                sel_hi   = snap_box_reg.hi[0];
                sel_size = cfg.size[0];
            end
            nvbb_pkg::AXIS_Y:
            begin
                sel_lo   = snap_box_reg.lo[1];
                sel_hi   = snap_box_reg.hi[1];
                sel_size = cfg.size[1];
            end
            default:
            begin
                sel_lo   = snap_box_reg.lo[2];
                sel_hi   = snap_box_reg.hi[2];
                sel_size = cfg.size[2];
            end
        endcase
    end

    // The clip limit is the size clamped to [1, MAX_DIM], minus one.
    always_comb
    begin
        ext     = sel_hi - sel_lo;
        product = PROD_W'(cfg.margin_fraction) * PROD_W'(ext);
        if (sel_size == '0)
        begin
            lim = '0;
        end
        else if (sel_size > SIZE_MAX)
        begin
            lim = '1;
        end
        else
        begin
            lim = nvbb_pkg::COORD_W'(sel_size - nvbb_pkg::SIZE_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (m_ready)
        begin
            m_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            m_axis_reg   <= issue_axis_reg;
            m_found_reg  <= snap_box_reg.found;
            m_lo_reg     <= sel_lo;
            m_hi_reg     <= sel_hi;
            m_margin_reg <= product[PROD_W-1:nvbb_pkg::FRAC_BITS];
            m_lim_reg    <= lim;
        end
    end

    always_comb
    begin
        pmin_w = $signed(WIDE_W'(m_lo_reg)) - $signed(WIDE_W'(m_margin_reg));
        pmax_w = $signed(WIDE_W'(m_hi_reg)) + $signed(WIDE_W'(m_margin_reg));
        lim_w  = $signed(WIDE_W'(m_lim_reg));
        if (pmin_w < PMIN_FLOOR)
        begin
            pmin_w = PMIN_FLOOR;
        end
        if (pmax_w > PMAX_CEIL)
        begin
            pmax_w = PMAX_CEIL;
        end
        cmin = pmin_w[WIDE_W-1] ? '0 : pmin_w[nvbb_pkg::COORD_W-1:0];
        cmax = (pmax_w > lim_w) ? m_lim_reg : pmax_w[nvbb_pkg::COORD_W-1:0];
        if (!m_found_reg)
        begin
            pmin_w = '0;
            pmax_w = '0;
            cmin   = '0;
            cmax   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && m_valid_reg)
        begin
            res.axis        <= m_axis_reg;
            res.found       <= m_found_reg;
            res.padded_min  <= pmin_w[nvbb_pkg::PAD_W-1:0];
            res.padded_max  <= pmax_w[nvbb_pkg::PAD_W-1:0];
            res.clipped_min <= cmin;
            res.clipped_max <= cmax;
            res.final_axis  <= (m_axis_reg == nvbb_pkg::AXIS_Z);
        end
    end

    assign res.valid = out_valid_reg;

`ifndef SYNTH
    a_snap_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        snap_load |-> (!snap_valid_reg || last_issue))
        else $error("box snapshot overwritten before all axes were issued");

    a_margin_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !out_load) |=> (m_valid_reg && $stable(m_axis_reg)))
        else $error("margin stage lost or changed a word while stalled");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.found) |->
            (res.padded_min == '0 && res.padded_max == '0 &&
             res.clipped_min == '0 && res.clipped_max == '0))
        else $error("empty box gave nonzero bounds");

    a_axis_order: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && !last_issue && !snap_load) |=> (snap_valid_reg &&
            issue_axis_reg != nvbb_pkg::AXIS_X))
        else $error("axis sequence broke off before the z word");
`endif

endmodule

`default_nettype wire

// File: src/nonzero_voxel_bounding_box.sv
// Top level of the nonzero voxel bounding box block.
// Throughput: one voxel word per cycle, except that after each end-of-set voxel the input
// is held off while the x and y words go to the margin stage, and longer when the
// output stalls; any voxel waits then, not only an end-of-set one.
// Result order: the x result word passes the snapshot, margin stage and output registers,
// followed by the y and z words on the next cycles when the output is not stalled.
// Reset clears the box, the configuration (margin 0, sizes 256) and all valid flags.
`default_nettype none

module nonzero_voxel_bounding_box (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [nvbb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [nvbb_pkg::CFG_DATA_W-1:0]   cfg_data,
    nvbb_voxel_if.sink                             vox,
    nvbb_result_if.source                          res
);

    nvbb_pkg::cfg_t cfg;
    nvbb_pkg::box_t snap_box;
    logic           snap_load;
    logic           snap_free;

    nvbb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nvbb_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .vox       (vox),
        .snap_free (snap_free),
        .snap_load (snap_load),
        .snap_box  (snap_box)
    );

    nvbb_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .snap_load (snap_load),
        .snap_box  (snap_box),
        .snap_free (snap_free),
        .res       (res)
    );

endmodule

`default_nettype wire

// File: dv/nonzero_voxel_bounding_box_tb.sv
// Self-checking testbench for the nonzero voxel bounding box block.
`timescale 1ns / 100ps

module nonzero_voxel_bounding_box_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 46;
    localparam int NUM_PHASES   = 6;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int NUM_DIRECTED = 18;

    typedef struct packed {
        logic [nvbb_pkg::VALUE_W-1:0] value;
        nvbb_pkg::coord_t             x;
        nvbb_pkg::coord_t             y;
        nvbb_pkg::coord_t             z;
        logic                         eos;
    } voxel_t;

    typedef struct packed {
        nvbb_pkg::axis_e                    axis;
        logic                               found;
        logic signed [nvbb_pkg::PAD_W-1:0]  pmin;
        logic [nvbb_pkg::PAD_W-1:0]         pmax;
        nvbb_pkg::coord_t                   cmin;
        nvbb_pkg::coord_t                   cmax;
        logic                               fin;
    } axis_result_t;

    // A typed row gives the same box for all three axes.
    typedef struct packed {
        logic [nvbb_pkg::VALUE_W-1:0]       value;
        nvbb_pkg::coord_t                   x;
        nvbb_pkg::coord_t                   y;
        nvbb_pkg::coord_t                   z;
        logic                               eos;
        logic                               typed;
        logic                               found;
        logic signed [nvbb_pkg::PAD_W-1:0]  pmin;
        logic [nvbb_pkg::PAD_W-1:0]         pmax;
        nvbb_pkg::coord_t                   cmin;
        nvbb_pkg::coord_t                   cmax;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [nvbb_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [nvbb_pkg::CFG_DATA_W-1:0] cfg_data;

    nvbb_voxel_if  vox_if ();
    nvbb_result_if res_if ();

    nonzero_voxel_bounding_box dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .vox       (vox_if),
        .res       (res_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bounding box predictor state and its copy of the registers.
    nvbb_pkg::coord_t              box_lo [nvbb_pkg::NUM_AXES];
    nvbb_pkg::coord_t              box_hi [nvbb_pkg::NUM_AXES];
    logic                          box_found;
    logic [nvbb_pkg::MARGIN_W-1:0] margin_q412;
    logic [nvbb_pkg::SIZE_W-1:0]   clip_size [nvbb_pkg::NUM_AXES];
    axis_result_t                  flush_result [nvbb_pkg::NUM_AXES];
    axis_result_t                  pending_axes [$];

    int   cycle_cnt     = 0;
    int   mismatch_cnt  = 0;
    int   axes_checked  = 0;
    int   voxels_sent   = 0;
    int   sets_closed   = 0;
    int   empty_sets    = 0;
    int   settings_used = 0;
    logic sender_paced  = 1'b1;
    logic hold_output_req = 1'b0;

    //    value     x     y     z  eos typed found pmin  pmax  cmin  cmax
    dir_row_t directed_rows [NUM_DIRECTED] = '{
        '{0,        5,    6,    7,    1, 1, 0, 0,    0,    0,    0},
        '{1,        0,    0,    0,    1, 1, 1, 0,    0,    0,    0},
        '{65535,    1023, 1023, 1023, 1, 1, 1, 1023, 1023, 1023, 255},
        '{0,        1023, 1023, 1023, 0, 0, 0, 0,    0,    0,    0},
        '{0,        0,    0,    0,    0, 0, 0, 0,    0,    0,    0},
        '{0,        3,    3,    3,    1, 1, 0, 0,    0,    0,    0},
        '{7,        10,   20,   30,   0, 0, 0, 0,    0,    0,    0},
        '{16'h8000, 1000, 2,    500,  0, 0, 0, 0,    0,    0,    0},
        '{0,        0,    1023, 0,    0, 0, 0, 0,    0,    0,    0},
        '{3,        512,  512,  512,  1, 0, 0, 0,    0,    0,    0},
        '{16'h00FF, 200,  300,  400,  0, 0, 0, 0,    0,    0,    0},
        '{0,        1,    1,    1,    1, 0, 0, 0,    0,    0,    0},
        '{1,        0,    1023, 0,    0, 0, 0, 0,    0,    0,    0},
        '{1,        1023, 0,    1023, 1, 0, 0, 0,    0,    0,    0},
        '{2,        100,  100,  100,  0, 0, 0, 0,    0,    0,    0},
        '{5,        50,   200,  50,   1, 0, 0, 0,    0,    0,    0},
        '{16'h5555, 255,  256,  254,  0, 0, 0, 0,    0,    0,    0},
        '{16'hAAAA, 257,  255,  256,  1, 0, 0, 0,    0,    0,    0}
    };

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at axis word %0d, %s: got %0d, expected %0d",
                 axes_checked, what, got, want);
        mismatch_cnt++;
    endtask

    function automatic void clear_box();
        for (int a = 0; a < nvbb_pkg::NUM_AXES; a++)
        begin
            box_lo[a] = '1;
            box_hi[a] = '0;
        end
        box_found = 1'b0;
    endfunction

    // Works out the three axis words of the set and starts a new one.
    function automatic void close_set();
        int lo, hi, margin, lim, pmin, pmax, cmin, cmax;
        axis_result_t r;
        sets_closed++;
        if (!box_found)
            empty_sets++;
        for (int a = 0; a < nvbb_pkg::NUM_AXES; a++)
        begin
            r = '0;
            if (box_found)
            begin
                lo = int'(box_lo[a]);
                hi = int'(box_hi[a]);
                margin = (int'(margin_q412) * (hi - lo)) >> nvbb_pkg::FRAC_BITS;
                lim = int'(clip_size[a]);
                if (lim > nvbb_pkg::MAX_DIM)
                    lim = nvbb_pkg::MAX_DIM;
                if (lim < 1)
                    lim = 1;
                lim = lim - 1;
                pmin = lo - margin;
                pmax = hi + margin;
                if (pmin < -16384)
                    pmin = -16384;
                if (pmax > 32767)
                    pmax = 32767;
                cmin = (pmin < 0) ? 0 : pmin;
                cmax = (pmax > lim) ? lim : pmax;
                r.found = 1'b1;
                r.pmin  = pmin[nvbb_pkg::PAD_W-1:0];
                r.pmax  = pmax[nvbb_pkg::PAD_W-1:0];
                r.cmin  = cmin[nvbb_pkg::COORD_W-1:0];
                r.cmax  = cmax[nvbb_pkg::COORD_W-1:0];
            end
            flush_result[a] = r;
        end
        clear_box();
    endfunction

    function automatic void accumulate_voxel(input voxel_t v);
        nvbb_pkg::coord_t p [nvbb_pkg::NUM_AXES];
        p[0] = v.x;
        p[1] = v.y;
        p[2] = v.z;
        if (v.value != '0)
        begin
            for (int a = 0; a < nvbb_pkg::NUM_AXES; a++)
            begin
                if (p[a] < box_lo[a])
                    box_lo[a] = p[a];
                if (p[a] > box_hi[a])
                    box_hi[a] = p[a];
            end
            box_found = 1'b1;
        end
        if (v.eos)
            close_set();
    endfunction

    task automatic program_reg(input nvbb_pkg::cfg_idx_e idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[nvbb_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        case (idx)
            nvbb_pkg::CFG_MARGIN: margin_q412 = value[nvbb_pkg::MARGIN_W-1:0];
            nvbb_pkg::CFG_SIZE_X: clip_size[nvbb_pkg::AXIS_X] = value[nvbb_pkg::SIZE_W-1:0];
            nvbb_pkg::CFG_SIZE_Y: clip_size[nvbb_pkg::AXIS_Y] = value[nvbb_pkg::SIZE_W-1:0];
            nvbb_pkg::CFG_SIZE_Z: clip_size[nvbb_pkg::AXIS_Z] = value[nvbb_pkg::SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int margin, input int sx, input int sy, input int sz);
        program_reg(nvbb_pkg::CFG_MARGIN, margin);
        program_reg(nvbb_pkg::CFG_SIZE_X, sx);
        program_reg(nvbb_pkg::CFG_SIZE_Y, sy);
        program_reg(nvbb_pkg::CFG_SIZE_Z, sz);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Waits until every expected axis word is back, then lets the pipeline drain.
    task automatic wait_drained();
        vox_if.valid <= 1'b0;
        while (pending_axes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_voxel(input voxel_t v, input logic use_typed,
                              input axis_result_t typed);
        int gap;
        axis_result_t r;
        gap = sender_paced ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            vox_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vox_if.valid       <= 1'b1;
        vox_if.voxel_value <= v.value;
        vox_if.pos_x       <= v.x;
        vox_if.pos_y       <= v.y;
        vox_if.pos_z       <= v.z;
        vox_if.end_of_set  <= v.eos;
        do
            @(posedge clk);
        while (vox_if.ready !== 1'b1);
        voxels_sent++;
        accumulate_voxel(v);
        if (v.eos)
        begin
            for (int a = 0; a < nvbb_pkg::NUM_AXES; a++)
            begin
                r = use_typed ? typed : flush_result[a];
                r.axis = nvbb_pkg::axis_e'(a);
                r.fin  = (a == nvbb_pkg::NUM_AXES - 1);
                pending_axes = {pending_axes, r};
            end
        end
    endtask

    function automatic nvbb_pkg::coord_t pick_coord(input logic clustered, input int center);
        int c;
        if (clustered)
        begin
            c = center + int'($urandom_range(0, 14)) - 7;
            if (c < 0)
                c = 0;
            if (c > nvbb_pkg::MAX_DIM - 1)
                c = nvbb_pkg::MAX_DIM - 1;
        end
        else
        begin
            case ($urandom_range(0, 7))
                0: c = 0;
                1: c = nvbb_pkg::MAX_DIM - 1;
                default: c = $urandom_range(0, nvbb_pkg::MAX_DIM - 1);
            endcase
        end
        return c[nvbb_pkg::COORD_W-1:0];
    endfunction

    function automatic logic [nvbb_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'hFFFF;
            1: return 16'h0001;
            default: return nvbb_pkg::VALUE_W'($urandom_range(1, 65535));
        endcase
    endfunction

    // Whole sets with random content; a few are single voxels or have no nonzero voxel.
    task automatic send_random_sets(input int budget);
        int sent, len, kind;
        int center [nvbb_pkg::NUM_AXES];
        voxel_t v;
        sent = 0;
        while (sent < budget)
        begin
            len  = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
            kind = $urandom_range(0, 9);
            for (int a = 0; a < nvbb_pkg::NUM_AXES; a++)
                center[a] = $urandom_range(0, nvbb_pkg::MAX_DIM - 1);
            for (int i = 0; i < len; i++)
            begin
                v.value = (kind == 0 || $urandom_range(0, 4) == 0) ? '0 : pick_value();
                v.x     = pick_coord(kind <= 3, center[0]);
                v.y     = pick_coord(kind <= 3, center[1]);
                v.z     = pick_coord(kind <= 3, center[2]);
                v.eos   = (i == len - 1);
                send_voxel(v, 1'b0, '0);
                sent++;
            end
        end
    endtask

    always @(posedge clk)
        cycle_cnt <= cycle_cnt + 1;

    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d axis words still expected",
                 cycle_cnt, pending_axes.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: checks each accepted word and stalls at random.
    initial
    begin
        int wait_left;
        int hold_left;
        axis_result_t want;
        wait_left = 0;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
            begin
                if (pending_axes.size() == 0)
                    report_mismatch("unexpected axis word, axis", int'(res_if.axis), -1);
                else
                begin
                    want = pending_axes.pop_front();
                    if (res_if.axis !== want.axis)
                        report_mismatch("axis", int'(res_if.axis), int'(want.axis));
                    if (res_if.found !== want.found)
                        report_mismatch("found", int'(res_if.found), int'(want.found));
                    if ($signed(res_if.padded_min) !== want.pmin)
                        report_mismatch("padded_min", int'($signed(res_if.padded_min)),
                                        int'(want.pmin));
                    if (res_if.padded_max !== want.pmax)
                        report_mismatch("padded_max", int'(res_if.padded_max),
                                        int'(want.pmax));
                    if (res_if.clipped_min !== want.cmin)
                        report_mismatch("clipped_min", int'(res_if.clipped_min),
                                        int'(want.cmin));
                    if (res_if.clipped_max !== want.cmax)
                        report_mismatch("clipped_max", int'(res_if.clipped_max),
                                        int'(want.cmax));
                    if (res_if.final_axis !== want.fin)
                        report_mismatch("final_axis", int'(res_if.final_axis),
                                        int'(want.fin));
                end
                axes_checked++;
                // Every third stretch of 30 words runs with no output stalls.
                wait_left = ((axes_checked / 30) % 3 == 1) ? 0 : $urandom_range(0, 17);
            end
            if (hold_output_req)
            begin
                hold_output_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // Voxel side: directed rows, then random sets under a series of register settings.
    initial
    begin
        voxel_t v;
        axis_result_t typed;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= nvbb_pkg::CFG_MARGIN;
        cfg_data           <= '0;
        vox_if.valid       <= 1'b0;
        vox_if.voxel_value <= '0;
        vox_if.pos_x       <= '0;
        vox_if.pos_y       <= '0;
        vox_if.pos_z       <= '0;
        vox_if.end_of_set  <= 1'b0;
        margin_q412 = '0;
        for (int a = 0; a < nvbb_pkg::NUM_AXES; a++)
            clip_size[a] = 11'd256;
        clear_box();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            v.value     = directed_rows[i].value;
            v.x         = directed_rows[i].x;
            v.y         = directed_rows[i].y;
            v.z         = directed_rows[i].z;
            v.eos       = directed_rows[i].eos;
            typed       = '0;
            typed.found = directed_rows[i].found;
            typed.pmin  = directed_rows[i].pmin;
            typed.pmax  = directed_rows[i].pmax;
            typed.cmin  = directed_rows[i].cmin;
            typed.cmax  = directed_rows[i].cmax;
            send_voxel(v, directed_rows[i].typed, typed);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            case (p)
                0: set_config(16'hFFFF, nvbb_pkg::MAX_DIM, nvbb_pkg::MAX_DIM,
                              nvbb_pkg::MAX_DIM);
                1: set_config(16'h1000, 0, 2047, 1);
                2: set_config($urandom_range(0, 65535), $urandom_range(1, nvbb_pkg::MAX_DIM),
                              $urandom_range(1, nvbb_pkg::MAX_DIM),
                              $urandom_range(1, nvbb_pkg::MAX_DIM));
                3: set_config(16'h0001, nvbb_pkg::MAX_DIM - 1, 512, 2);
                4: set_config($urandom_range(0, 65535), $urandom_range(0, 2047),
                              $urandom_range(0, 2047), $urandom_range(0, 2047));
                default: set_config(16'h0800, 256, 256, 256);
            endcase
            // Two phases send back to back; in the first the output is held off
            // long enough for the block to fill and push back on its input.
            sender_paced = (p != 1) && (p != 4);
            if (p == 1)
                hold_output_req = 1'b1;
            send_random_sets(PHASE_ITEMS);
        end

        wait_drained();
        repeat (16) @(posedge clk);
        $display("Run covered %0d voxel words in %0d sets (%0d empty) under %0d settings.",
                 voxels_sent, sets_closed, empty_sets, settings_used + 1);
        $display("Checked %0d axis words with %0d mismatches.", axes_checked, mismatch_cnt);
        if (mismatch_cnt == 0 && pending_axes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
